FILE: design/hgi_pkg.sv
// shared types, codes and helpers for the hrtf grid interpolator
package hgi_pkg;

    localparam int AZ_POINTS_DEF = 25;
    localparam int EL_POINTS_DEF = 50;
    localparam int BINS_DEF      = 256;

    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam int          FULL_TURN = 23040;

    // input command codes
    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_TWRITE = 2'd1;
    localparam logic [1:0] CMD_DWRITE = 2'd2;

    // classes handed from front to back
    localparam logic [1:0] CLS_QUERY  = 2'd0;
    localparam logic [1:0] CLS_TWRITE = 2'd1;
    localparam logic [1:0] CLS_DWRITE = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_INTERP = 1'b0;
    localparam logic REG_MIND   = 1'b1;

    typedef struct packed {
        logic [1:0]         cls;
        logic [4:0]         az_index;
        logic [5:0]         el_index;
        logic [7:0]         bin;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        logic signed [13:0] azimuth;
        logic signed [15:0] elevation;
        logic [15:0]        distance;
    } item_t;

    typedef struct packed {
        logic        interpolate;
        logic [15:0] min_distance;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic signed [18:0] off;
        logic signed [18:0] span;
    } frac_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] value;
    } frac_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

FILE: design/hgi_frac.sv
// serial fraction unit: floor(off*65536/span) clamped to 0..65536
module hgi_frac (
    input  logic                aclk,
    input  logic                aresetn,
    input  hgi_pkg::frac_req_t  req,
    output hgi_pkg::frac_rsp_t  rsp
);
    import hgi_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [17:0] rem_reg, rem_next;
    logic [17:0] span_reg, span_next;
    logic [15:0] q_reg, q_next;
    logic [16:0] res_reg, res_next;
    logic [18:0] rem2;

    assign rem2 = {rem_reg, 1'b0};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        span_next = span_reg;
        q_next    = q_reg;
        res_next  = res_reg;
        if (req.start) begin
            if (req.span <= 0 || req.off <= 0) begin
                res_next  = '0;
                done_next = 1'b1;
            end else if (req.off >= req.span) begin
                res_next  = ONE_Q16;
                done_next = 1'b1;
            end else begin
                rem_next  = req.off[17:0];
                span_next = req.span[17:0];
                q_next    = '0;
                cnt_next  = 5'd16;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            // one quotient bit a cycle
            if (rem2 >= {1'b0, span_reg}) begin
                rem_next = 18'(rem2 - {1'b0, span_reg});
                q_next   = {q_reg[14:0], 1'b1};
            end else begin
                rem_next = rem2[17:0];
                q_next   = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = {1'b0, q_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        span_reg <= span_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

FILE: design/hgi_front.sv
// input side: unpacks and classifies items into a two-entry queue
module hgi_front #(
    parameter int AZ_POINTS = hgi_pkg::AZ_POINTS_DEF,
    parameter int EL_POINTS = hgi_pkg::EL_POINTS_DEF,
    parameter int BINS      = hgi_pkg::BINS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hgi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [hgi_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            q_valid,
    output hgi_pkg::item_t                  q_item,
    input  logic                            q_pop
);
    import hgi_pkg::*;

    item_t       slot_mem [2];
    item_t       in_item;
    logic        keep;
    logic        push;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    always_comb begin
        in_item.az_index    = s_tdata[4:0];
        in_item.el_index    = s_tdata[10:5];
        in_item.bin         = s_tdata[18:11];
        in_item.left_value  = s_tdata[50:19];
        in_item.right_value = s_tdata[82:51];
        in_item.azimuth     = s_tdata[96:83];
        in_item.elevation   = s_tdata[112:97];
        in_item.distance    = s_tdata[128:113];
        in_item.cls         = CLS_QUERY;
        keep                = 1'b0;
        case (s_tuser)
            CMD_QUERY: begin
                keep = 1'b1;
            end
            CMD_TWRITE: begin
                in_item.cls = CLS_TWRITE;
                keep = (32'(in_item.az_index) < AZ_POINTS) &&
                       (32'(in_item.el_index) < EL_POINTS) &&
                       (32'(in_item.bin) < BINS);
            end
            CMD_DWRITE: begin
                in_item.cls = CLS_DWRITE;
                keep = 32'(in_item.bin) < BINS;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_tready = cnt_reg != 2'd2;
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = q_pop && cnt_reg != 2'd0;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = slot_mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: design/hgi_back.sv
// back end: table memories, grid scan, blend and distance fade
module hgi_back #(
    parameter int AZ_POINTS = hgi_pkg::AZ_POINTS_DEF,
    parameter int EL_POINTS = hgi_pkg::EL_POINTS_DEF,
    parameter int BINS      = hgi_pkg::BINS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  hgi_pkg::item_t                  q_item,
    output logic                            q_pop,
    input  hgi_pkg::cfg_t                   cfg,
    output hgi_pkg::frac_req_t              fr_req,
    input  hgi_pkg::frac_rsp_t              fr_rsp,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hgi_pkg::M_TDATA_W-1:0]   m_tdata
);
    import hgi_pkg::*;

    localparam int DEPTH = AZ_POINTS * EL_POINTS * BINS;
    localparam int ADW   = $clog2(DEPTH);
    localparam int BIW   = $clog2(BINS);
    localparam int AIW   = $clog2(AZ_POINTS);
    localparam int EIW   = $clog2(EL_POINTS);
    localparam int MAXP  = (AZ_POINTS > EL_POINTS) ? AZ_POINTS : EL_POINTS;
    localparam int SW    = $clog2(MAXP);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_AZW  = 4'd2;
    localparam logic [3:0] ST_AZD  = 4'd3;
    localparam logic [3:0] ST_ELW  = 4'd4;
    localparam logic [3:0] ST_ELD  = 4'd5;
    localparam logic [3:0] ST_PW   = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_ACC  = 4'd8;
    localparam logic [3:0] ST_FADE = 4'd9;
    localparam logic [3:0] ST_FDIV = 4'd10;
    localparam logic [3:0] ST_FMUL = 4'd11;
    localparam logic [3:0] ST_FSUM = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic signed [17:0] az_grid [AZ_POINTS];
    logic signed [17:0] el_grid [EL_POINTS];

    for (genvar g = 0; g < AZ_POINTS; g++) begin : g_az
        localparam int AV = (AZ_POINTS == 25) ?
            ((g == 0) ? -5120 : (g == 1) ? -4160 : (g == 2) ? -3520 :
             (g == 22) ? 3520 : (g == 23) ? 4160 : (g == 24) ? 5120 :
             -3840 + 320 * g) :
            -5120 + (10240 * g) / (AZ_POINTS - 1);
        assign az_grid[g] = 18'(AV);
    end
    for (genvar g = 0; g < EL_POINTS; g++) begin : g_el
        localparam int EV = -2880 + 360 * g;
        assign el_grid[g] = 18'(EV);
    end

    logic signed [31:0] left_mem   [DEPTH];
    logic signed [31:0] right_mem  [DEPTH];
    logic signed [31:0] direct_mem [BINS];

    logic [3:0]         st_reg, st_next;
    logic               ov_reg, ov_next;
    logic signed [13:0] az_reg, az_next;
    logic signed [15:0] el_reg, el_next;
    logic [15:0]        dist_reg, dist_next;
    logic [7:0]         bin_reg, bin_next;
    logic [SW-1:0]      idx_reg, idx_next;
    logic               azf_reg, azf_next;
    logic               elf_reg, elf_next;
    logic [AIW-1:0]     az_hi_reg, az_hi_next;
    logic [EIW-1:0]     el_hi_reg, el_hi_next;
    logic [AIW-1:0]     az_nr_reg, az_nr_next;
    logic [EIW-1:0]     el_nr_reg, el_nr_next;
    logic [18:0]        az_be_reg, az_be_next;
    logic [18:0]        el_be_reg, el_be_next;
    logic [AIW-1:0]     ai0_reg, ai0_next, ai1_reg, ai1_next;
    logic [EIW-1:0]     ei0_reg, ei0_next, ei1_reg, ei1_next;
    logic [16:0]        wa0_reg, wa0_next, wa1_reg, wa1_next;
    logic [16:0]        we0_reg, we0_next, we1_reg, we1_next;
    logic [1:0]         k_reg, k_next;
    logic [1:0]         lastk_reg, lastk_next;
    logic [17:0]        pw_reg, pw_next;
    logic signed [50:0] pl_reg, pl_next, pr_reg, pr_next;
    logic signed [51:0] accl_reg, accl_next, accr_reg, accr_next;
    logic [16:0]        f_reg, f_next;
    logic signed [49:0] ml_reg, ml_next, mr_reg, mr_next, md_reg, md_next;
    logic signed [31:0] resl_reg, resl_next, resr_reg, resr_next;
    logic signed [31:0] outl_reg, outl_next, outr_reg, outr_next;
    logic [7:0]         outb_reg, outb_next;
    logic signed [31:0] ld_reg, rd_reg, dd_reg;

    logic               tw_en, dw_en;
    logic [ADW-1:0]     wr_addr, rd_addr;
    logic [AIW-1:0]     ca;
    logic [EIW-1:0]     ce;
    logic [BIW-1:0]     bin_idx;
    logic               az_ok, el_ok;
    logic [AIW-1:0]     aidx;
    logic [EIW-1:0]     eidx;
    logic signed [17:0] azq, elq, az_g, el_g;
    logic signed [18:0] az_d, el_d;
    logic [18:0]        az_abs, el_abs;
    logic signed [18:0] el_wrap;
    logic [33:0]        wprod;
    logic signed [31:0] lsat, rsat;
    logic signed [50:0] fsum_l, fsum_r;
    logic [16:0]        wpa, wpe;

    assign tw_en   = st_reg == ST_IDLE && q_valid && q_item.cls == CLS_TWRITE;
    assign dw_en   = st_reg == ST_IDLE && q_valid && q_item.cls == CLS_DWRITE;
    assign wr_addr = ADW'((int'(q_item.az_index) * EL_POINTS + int'(q_item.el_index)) * BINS
                          + int'(q_item.bin));
    assign ca      = k_reg[1] ? ai1_reg : ai0_reg;
    assign ce      = k_reg[0] ? ei1_reg : ei0_reg;
    assign rd_addr = ADW'((int'(ca) * EL_POINTS + int'(ce)) * BINS + int'(bin_reg));
    assign bin_idx = BIW'(bin_reg);

    always_ff @(posedge aclk) begin
        if (tw_en) begin
            left_mem[wr_addr]  <= q_item.left_value;
            right_mem[wr_addr] <= q_item.right_value;
        end
        ld_reg <= left_mem[rd_addr];
        rd_reg <= right_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (dw_en) begin
            direct_mem[BIW'(q_item.bin)] <= q_item.left_value;
        end
        dd_reg <= direct_mem[bin_idx];
    end

    // grid scan, one point of each grid per cycle; also weight product, saturation and fade sums
    always_comb begin
        azq    = 18'(az_reg);
        elq    = 18'(el_reg);
        az_ok  = 32'(idx_reg) < AZ_POINTS;
        el_ok  = 32'(idx_reg) < EL_POINTS;
        aidx   = az_ok ? AIW'(idx_reg) : '0;
        eidx   = el_ok ? EIW'(idx_reg) : '0;
        az_g   = az_grid[aidx];
        el_g   = el_grid[eidx];
        az_d   = 19'(azq) - 19'(az_g);
        el_d   = 19'(elq) - 19'(el_g);
        az_abs = (az_d < 0) ? 19'(-az_d) : 19'(az_d);
        el_abs = (el_d < 0) ? 19'(-el_d) : 19'(el_d);
        el_wrap = (elq < el_grid[0]) ? 19'(elq) + 19'(FULL_TURN) : 19'(elq);
        wpa    = k_reg[1] ? wa1_reg : wa0_reg;
        wpe    = k_reg[0] ? we1_reg : we0_reg;
        wprod  = wpa * wpe;
        lsat   = sat32(36'(accl_reg >>> 16));
        rsat   = sat32(36'(accr_reg >>> 16));
        fsum_l = 51'(ml_reg) + 51'(md_reg);
        fsum_r = 51'(mr_reg) + 51'(md_reg);
    end

    always_comb begin
        st_next    = st_reg;
        ov_next    = ov_reg && !m_tready;
        az_next    = az_reg;
        el_next    = el_reg;
        dist_next  = dist_reg;
        bin_next   = bin_reg;
        idx_next   = idx_reg;
        azf_next   = azf_reg;
        elf_next   = elf_reg;
        az_hi_next = az_hi_reg;
        el_hi_next = el_hi_reg;
        az_nr_next = az_nr_reg;
        el_nr_next = el_nr_reg;
        az_be_next = az_be_reg;
        el_be_next = el_be_reg;
        ai0_next   = ai0_reg;
        ai1_next   = ai1_reg;
        ei0_next   = ei0_reg;
        ei1_next   = ei1_reg;
        wa0_next   = wa0_reg;
        wa1_next   = wa1_reg;
        we0_next   = we0_reg;
        we1_next   = we1_reg;
        k_next     = k_reg;
        lastk_next = lastk_reg;
        pw_next    = pw_reg;
        pl_next    = pl_reg;
        pr_next    = pr_reg;
        accl_next  = accl_reg;
        accr_next  = accr_reg;
        f_next     = f_reg;
        ml_next    = ml_reg;
        mr_next    = mr_reg;
        md_next    = md_reg;
        resl_next  = resl_reg;
        resr_next  = resr_reg;
        outl_next  = outl_reg;
        outr_next  = outr_reg;
        outb_next  = outb_reg;
        q_pop      = 1'b0;
        fr_req     = '0;
        case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    az_next   = q_item.azimuth;
                    el_next   = q_item.elevation;
                    dist_next = q_item.distance;
                    bin_next  = q_item.bin;
                    if (q_item.cls == CLS_QUERY) begin
                        if (32'(q_item.bin) < BINS) begin
                            idx_next   = '0;
                            azf_next   = 1'b0;
                            elf_next   = 1'b0;
                            az_hi_next = AIW'(AZ_POINTS - 1);
                            el_hi_next = '0;
                            st_next    = ST_SCAN;
                        end else begin
                            resl_next = '0;
                            resr_next = '0;
                            st_next   = ST_OUT;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (az_ok && idx_reg != '0 && !azf_reg && az_g >= azq) begin
                    azf_next   = 1'b1;
                    az_hi_next = aidx;
                end
                if (el_ok && !elf_reg && el_g >= elq) begin
                    elf_next   = 1'b1;
                    el_hi_next = eidx;
                end
                if (az_ok && (idx_reg == '0 || az_abs < az_be_reg)) begin
                    az_be_next = az_abs;
                    az_nr_next = aidx;
                end
                if (el_ok && (idx_reg == '0 || el_abs < el_be_reg)) begin
                    el_be_next = el_abs;
                    el_nr_next = eidx;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SW'(MAXP - 1)) begin
                    st_next = ST_AZW;
                end
            end
            ST_AZW: begin
                accl_next = '0;
                accr_next = '0;
                k_next    = '0;
                if (!cfg.interpolate) begin
                    ai0_next   = az_nr_reg;
                    ei0_next   = el_nr_reg;
                    wa0_next   = ONE_Q16;
                    we0_next   = ONE_Q16;
                    lastk_next = 2'd0;
                    st_next    = ST_PW;
                end else if (azq <= az_grid[0]) begin
                    ai0_next = '0;
                    ai1_next = '0;
                    wa0_next = HALF_Q16;
                    wa1_next = HALF_Q16;
                    st_next  = ST_ELW;
                end else if (azq >= az_grid[AZ_POINTS - 1]) begin
                    ai0_next = AIW'(AZ_POINTS - 1);
                    ai1_next = AIW'(AZ_POINTS - 1);
                    wa0_next = HALF_Q16;
                    wa1_next = HALF_Q16;
                    st_next  = ST_ELW;
                end else begin
                    ai0_next     = az_hi_reg - 1'b1;
                    ai1_next     = az_hi_reg;
                    fr_req.start = 1'b1;
                    fr_req.off   = 19'(azq) - 19'(az_grid[az_hi_reg - 1'b1]);
                    fr_req.span  = 19'(az_grid[az_hi_reg]) - 19'(az_grid[az_hi_reg - 1'b1]);
                    st_next      = ST_AZD;
                end
            end
            ST_AZD: begin
                if (fr_rsp.done) begin
                    wa1_next = fr_rsp.value;
                    wa0_next = ONE_Q16 - fr_rsp.value;
                    st_next  = ST_ELW;
                end
            end
            ST_ELW: begin
                fr_req.start = 1'b1;
                if (elf_reg && el_hi_reg != '0) begin
                    ei0_next    = el_hi_reg - 1'b1;
                    ei1_next    = el_hi_reg;
                    fr_req.off  = 19'(elq) - 19'(el_grid[el_hi_reg - 1'b1]);
                    fr_req.span = 19'(el_grid[el_hi_reg]) - 19'(el_grid[el_hi_reg - 1'b1]);
                end else begin
                    // blend across the full-turn wrap
                    ei0_next    = EIW'(EL_POINTS - 1);
                    ei1_next    = '0;
                    fr_req.off  = el_wrap - 19'(el_grid[EL_POINTS - 1]);
                    fr_req.span = 19'(el_grid[0]) + 19'(FULL_TURN)
                                  - 19'(el_grid[EL_POINTS - 1]);
                end
                st_next = ST_ELD;
            end
            ST_ELD: begin
                if (fr_rsp.done) begin
                    we1_next   = fr_rsp.value;
                    we0_next   = ONE_Q16 - fr_rsp.value;
                    lastk_next = 2'd3;
                    st_next    = ST_PW;
                end
            end
            ST_PW: begin
                pw_next = wprod[33:16];
                st_next = ST_MUL;
            end
            ST_MUL: begin
                pl_next = ld_reg * $signed({1'b0, pw_reg});
                pr_next = rd_reg * $signed({1'b0, pw_reg});
                st_next = ST_ACC;
            end
            ST_ACC: begin
                accl_next = accl_reg + 52'(pl_reg);
                accr_next = accr_reg + 52'(pr_reg);
                if (k_reg == lastk_reg) begin
                    st_next = ST_FADE;
                end else begin
                    k_next  = k_reg + 2'd1;
                    st_next = ST_PW;
                end
            end
            ST_FADE: begin
                resl_next = lsat;
                resr_next = rsat;
                if (cfg.min_distance != '0 && dist_reg < cfg.min_distance) begin
                    fr_req.start = 1'b1;
                    fr_req.off   = 19'(dist_reg);
                    fr_req.span  = 19'(cfg.min_distance);
                    st_next      = ST_FDIV;
                end else begin
                    st_next = ST_OUT;
                end
            end
            ST_FDIV: begin
                if (fr_rsp.done) begin
                    f_next  = fr_rsp.value;
                    st_next = ST_FMUL;
                end
            end
            ST_FMUL: begin
                ml_next = resl_reg * $signed({1'b0, f_reg});
                mr_next = resr_reg * $signed({1'b0, f_reg});
                md_next = dd_reg * $signed({1'b0, ONE_Q16 - f_reg});
                st_next = ST_FSUM;
            end
            ST_FSUM: begin
                resl_next = sat32(36'(fsum_l >>> 16));
                resr_next = sat32(36'(fsum_r >>> 16));
                st_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!ov_reg || m_tready) begin
                    outl_next = resl_reg;
                    outr_next = resr_reg;
                    outb_next = bin_reg;
                    ov_next   = 1'b1;
                    st_next   = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        az_reg    <= az_next;
        el_reg    <= el_next;
        dist_reg  <= dist_next;
        bin_reg   <= bin_next;
        idx_reg   <= idx_next;
        azf_reg   <= azf_next;
        elf_reg   <= elf_next;
        az_hi_reg <= az_hi_next;
        el_hi_reg <= el_hi_next;
        az_nr_reg <= az_nr_next;
        el_nr_reg <= el_nr_next;
        az_be_reg <= az_be_next;
        el_be_reg <= el_be_next;
        ai0_reg   <= ai0_next;
        ai1_reg   <= ai1_next;
        ei0_reg   <= ei0_next;
        ei1_reg   <= ei1_next;
        wa0_reg   <= wa0_next;
        wa1_reg   <= wa1_next;
        we0_reg   <= we0_next;
        we1_reg   <= we1_next;
        k_reg     <= k_next;
        lastk_reg <= lastk_next;
        pw_reg    <= pw_next;
        pl_reg    <= pl_next;
        pr_reg    <= pr_next;
        accl_reg  <= accl_next;
        accr_reg  <= accr_next;
        f_reg     <= f_next;
        ml_reg    <= ml_next;
        mr_reg    <= mr_next;
        md_reg    <= md_next;
        resl_reg  <= resl_next;
        resr_reg  <= resr_next;
        outl_reg  <= outl_next;
        outr_reg  <= outr_next;
        outb_reg  <= outb_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {outb_reg, outr_reg, outl_reg};

endmodule

FILE: design/hrtf_grid_interpolator_top.sv
// top level of the hrtf grid interpolator: config registers and channel wiring
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tuser: cmd; tdata: write and query fields
// m_        out  m_tvalid/m_tready    tdata: left_coef, right_coef, bin_out
// apb       in   psel/penable/pready  interpolate @0x0, min_distance @0x4
//
// a table write or direct write is taken by the back end from the idle state; a
// query runs a serial grid scan over max(AZ_POINTS, EL_POINTS) points, up to two
// fraction divisions on the shared divider and a blend of the table entries, plus
// a further division and blend when the distance fade applies. reset is
// synchronous; the tables are not cleared. a two-entry queue and the output
// register let either side stall.
module hrtf_grid_interpolator_top #(
    parameter int AZ_POINTS = hgi_pkg::AZ_POINTS_DEF,
    parameter int EL_POINTS = hgi_pkg::EL_POINTS_DEF,
    parameter int BINS      = hgi_pkg::BINS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // az_index, el_index, bin, left_value, right_value, azimuth, elevation, distance
    input  logic [hgi_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [hgi_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // left_coef, right_coef, bin_out
    output logic [hgi_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import hgi_pkg::*;

    logic        interp_reg;
    logic [15:0] mind_reg;
    logic        cfg_wr;
    cfg_t        cfg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    frac_req_t   fr_req;
    frac_rsp_t   fr_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interp_reg <= 1'b1;
            mind_reg   <= 16'd256;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_INTERP: interp_reg <= pwdata[0];
                REG_MIND:   mind_reg   <= pwdata[15:0];
                default:    interp_reg <= interp_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INTERP: prdata = {31'd0, interp_reg};
            REG_MIND:   prdata = {16'd0, mind_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.interpolate  = interp_reg;
    assign cfg.min_distance = mind_reg;

    hgi_front #(
        .AZ_POINTS(AZ_POINTS),
        .EL_POINTS(EL_POINTS),
        .BINS(BINS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop)
    );

    hgi_frac u_frac (
        .aclk(aclk),
        .aresetn(aresetn),
        .req(fr_req),
        .rsp(fr_rsp)
    );

    hgi_back #(
        .AZ_POINTS(AZ_POINTS),
        .EL_POINTS(EL_POINTS),
        .BINS(BINS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop),
        .cfg(cfg),
        .fr_req(fr_req),
        .fr_rsp(fr_rsp),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

endmodule

FILE: tb/sv/tb_hrtf_grid_interpolator_top.sv
// testbench for the hrtf grid interpolator: directed and random writes and queries
`timescale 1ns / 100ps

module tb_hrtf_grid_interpolator_top;
    import hgi_pkg::*;

    localparam int AZN = 25;
    localparam int ELN = 50;
    localparam int NB  = 256;
    localparam longint LIMIT = 4000000;

    typedef struct {
        logic [1:0]         cmd;
        logic [4:0]         az_index;
        logic [5:0]         el_index;
        logic [7:0]         bin;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        logic signed [13:0] azimuth;
        logic signed [15:0] elevation;
        logic [15:0]        distance;
    } req_t;

    typedef struct {
        logic signed [31:0] left_coef;
        logic signed [31:0] right_coef;
        logic [7:0]         bin_out;
    } coef_t;

    // predictor of the coefficient lookup, with its own copy of the tables
    class coef_scoreboard;
        int signed   left_tab[int];
        int signed   right_tab[int];
        int signed   direct_tab[NB];
        bit          written[int];
        bit          dwritten[NB];
        longint      az_grid[AZN];
        longint      el_grid[ELN];
        bit          interp;
        longint      min_dist;
        coef_t       pending[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < AZN; i++) begin
                if (i == 0) az_grid[i] = -5120;
                else if (i == 1) az_grid[i] = -4160;
                else if (i == 2) az_grid[i] = -3520;
                else if (i == 22) az_grid[i] = 3520;
                else if (i == 23) az_grid[i] = 4160;
                else if (i == 24) az_grid[i] = 5120;
                else az_grid[i] = -3840 + 320 * i;
            end
            for (int i = 0; i < ELN; i++) el_grid[i] = -2880 + 360 * i;
            interp = 1;
            min_dist = 256;
            errors = 0;
            checked = 0;
        endfunction

        function int key(int a, int e, int b);
            return (a * ELN + e) * NB + b;
        endfunction

        function longint floor16(longint x);
            return x >>> 16;
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint weight_of(longint off, longint span);
            longint t;
            if (span <= 0 || off <= 0) return 0;
            if (off >= span) return 65536;
            t = (off * 65536) / span;
            return t > 65536 ? 65536 : t;
        endfunction

        function longint mix4(bit right, int ai[2], longint wa[2], int ei[2],
                              longint we[2], int b);
            longint acc;
            longint w;
            int k;
            acc = 0;
            for (int p = 0; p < 2; p++)
                for (int q = 0; q < 2; q++) begin
                    w = (wa[p] * we[q]) >>> 16;
                    k = key(ai[p], ei[q], b);
                    if (written.exists(k))
                        acc += longint'(right ? right_tab[k] : left_tab[k]) * w;
                end
            return floor16(acc);
        endfunction

        function int closest_az(longint x);
            int best;
            longint err, best_err;
            best = 0;
            best_err = -1;
            for (int i = 0; i < AZN; i++) begin
                err = x - az_grid[i];
                if (err < 0) err = -err;
                if (best_err < 0 || err < best_err) begin
                    best_err = err;
                    best = i;
                end
            end
            return best;
        endfunction

        function int closest_el(longint x);
            int best;
            longint err, best_err;
            best = 0;
            best_err = -1;
            for (int i = 0; i < ELN; i++) begin
                err = x - el_grid[i];
                if (err < 0) err = -err;
                if (best_err < 0 || err < best_err) begin
                    best_err = err;
                    best = i;
                end
            end
            return best;
        endfunction

        function void note_item(req_t r);
            coef_t c;
            longint az, el, l, rr, t, e, f, d;
            int ai[2], ei[2];
            longint wa[2], we[2];
            int hi, b, k;
            b = r.bin;
            if (r.cmd == CMD_TWRITE) begin
                if (r.az_index < AZN && r.el_index < ELN) begin
                    k = key(r.az_index, r.el_index, b);
                    left_tab[k] = r.left_value;
                    right_tab[k] = r.right_value;
                    written[k] = 1;
                end
                return;
            end
            if (r.cmd == CMD_DWRITE) begin
                direct_tab[b] = r.left_value;
                dwritten[b] = 1;
                return;
            end
            if (r.cmd != CMD_QUERY) return;
            az = r.azimuth;
            el = r.elevation;
            if (interp) begin
                hi = -1;
                if (az <= az_grid[0]) begin
                    ai[0] = 0; ai[1] = 0; wa[0] = 32768; wa[1] = 32768;
                end else if (az >= az_grid[AZN-1]) begin
                    ai[0] = AZN-1; ai[1] = AZN-1; wa[0] = 32768; wa[1] = 32768;
                end else begin
                    for (int i = 1; i < AZN; i++)
                        if (hi < 0 && az_grid[i] >= az) hi = i;
                    ai[0] = hi - 1;
                    ai[1] = hi;
                    t = weight_of(az - az_grid[hi-1], az_grid[hi] - az_grid[hi-1]);
                    wa[1] = t;
                    wa[0] = 65536 - t;
                end
                hi = -1;
                for (int i = 0; i < ELN; i++)
                    if (hi < 0 && el_grid[i] >= el) hi = i;
                if (hi > 0) begin
                    ei[0] = hi - 1;
                    ei[1] = hi;
                    t = weight_of(el - el_grid[hi-1], el_grid[hi] - el_grid[hi-1]);
                end else begin
                    e = (el < el_grid[0]) ? el + FULL_TURN : el;
                    ei[0] = ELN - 1;
                    ei[1] = 0;
                    t = weight_of(e - el_grid[ELN-1], el_grid[0] + FULL_TURN - el_grid[ELN-1]);
                end
                we[1] = t;
                we[0] = 65536 - t;
                l = mix4(0, ai, wa, ei, we, b);
                rr = mix4(1, ai, wa, ei, we, b);
            end else begin
                k = key(closest_az(az), closest_el(el), b);
                l = written.exists(k) ? left_tab[k] : 0;
                rr = written.exists(k) ? right_tab[k] : 0;
            end
            if (min_dist != 0 && longint'(r.distance) < min_dist) begin
                f = (longint'(r.distance) * 65536) / min_dist;
                d = dwritten[b] ? direct_tab[b] : 0;
                l = floor16(clip32(l) * f + d * (65536 - f));
                rr = floor16(clip32(rr) * f + d * (65536 - f));
            end
            c.left_coef = 32'(clip32(l));
            c.right_coef = 32'(clip32(rr));
            c.bin_out = r.bin;
            pending.push_back(c);
        endfunction

        function void check_result(coef_t got);
            coef_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: l=%0d r=%0d bin=%0d",
                             got.left_coef, got.right_coef, got.bin_out);
                return;
            end
            want = pending.pop_front();
            if (want.left_coef !== got.left_coef || want.right_coef !== got.right_coef ||
                want.bin_out !== got.bin_out) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: expected l=%0d r=%0d bin=%0d, got l=%0d r=%0d bin=%0d",
                             checked, want.left_coef, want.right_coef, want.bin_out,
                             got.left_coef, got.right_coef, got.bin_out);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    coef_scoreboard sb = new();
    longint cycles = 0;
    bit     hold_off = 0;
    bit     long_gaps = 1;
    int     n_items = 0;
    int     n_queries = 0;
    int     fill_az[$];
    int     fill_el[$];

    always #2 aclk = ~aclk;

    hrtf_grid_interpolator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[hrtf_grid_interpolator_top] ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return long_gaps ? $urandom_range(8, 40) : 1;
    endfunction

    // result side: each accepted result is checked; the next block adds random stalls and a long hold-off when asked
    always @(posedge aclk) begin
        coef_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.left_coef = m_tdata[31:0];
                got.right_coef = m_tdata[63:32];
                got.bin_out = m_tdata[71:64];
                sb.check_result(got);
            end
        end
    end

    initial begin
        int g;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            m_tready <= 1;
            @(posedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    task automatic send(req_t r);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= r.cmd;
        s_tdata <= {7'd0, r.distance, r.elevation, r.azimuth, r.right_value, r.left_value,
                    r.bin, r.el_index, r.az_index};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(r);
        n_items++;
        if (r.cmd == CMD_QUERY) n_queries++;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr[2] == REG_MIND) sb.min_dist = val[15:0];
        else sb.interp = val[0];
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic req_t blank();
        req_t r;
        r.cmd = CMD_QUERY;
        r.az_index = 0; r.el_index = 0; r.bin = 0;
        r.left_value = 0; r.right_value = 0;
        r.azimuth = 0; r.elevation = 0; r.distance = 16'hffff;
        return r;
    endfunction

    // direct entries per bin, then table writes in the outer azimuth columns 0..3, 21..24
    // at every elevation; queries stay at azimuths beyond +-2880 so they only touch these
    task automatic load_tables(int nbins);
        req_t r;
        for (int b = 0; b < nbins; b++) begin
            r = blank();
            r.cmd = CMD_DWRITE;
            r.bin = 8'(b);
            r.left_value = $urandom();
            r.right_value = $urandom();
            send(r);
        end
        for (int a = 0; a < AZN; a++)
            for (int e = 0; e < ELN; e++)
                for (int b = 0; b < nbins; b++) begin
                    if (a > 3 && a < 21) continue;
                    r = blank();
                    r.cmd = CMD_TWRITE;
                    r.az_index = 5'(a); r.el_index = 6'(e); r.bin = 8'(b);
                    r.left_value = ($urandom_range(0, 7) == 0) ?
                                   ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000) :
                                   $urandom();
                    r.right_value = $urandom();
                    send(r);
                end
    endtask

    function automatic req_t rand_query(int nbins);
        req_t r;
        int p;
        int mag;
        r = blank();
        r.bin = 8'($urandom_range(0, nbins - 1));
        p = $urandom_range(0, 9);
        mag = (p == 0) ? $urandom_range(2881, 8191) : $urandom_range(2881, 5760);
        r.azimuth = $urandom_range(0, 1) ? 14'(mag) : 14'(-mag);
        r.elevation = (p == 1) ? 16'($urandom()) : 16'($urandom_range(0, 23040) - 5760);
        p = $urandom_range(0, 3);
        r.distance = (p == 0) ? 16'($urandom_range(0, 1024)) : 16'($urandom());
        r.az_index = $urandom(); r.el_index = $urandom();
        r.left_value = $urandom(); r.right_value = $urandom();
        return r;
    endfunction

    localparam int QBINS = 1;

    initial begin
        req_t r;
        int unsigned mds[6];
        mds = '{256, 1, 65535, 1000, 0, 300};
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        apb_write(3'(4 * 1), 32'd256);

        // fill bin 0 in the outer columns, plus its direct entry; no long gaps here
        long_gaps = 0;
        load_tables(QBINS);
        long_gaps = 1;

        // ignored writes: index out of range, unknown command; then a direct write to a bin left unqueried
        r = blank(); r.cmd = CMD_TWRITE; r.az_index = 5'd31; r.el_index = 6'd63;
        r.bin = 8'd255; r.left_value = 32'sh7fffffff; r.right_value = 32'sh80000000;
        send(r);
        r = blank(); r.cmd = CMD_TWRITE; r.az_index = 5'd25; r.el_index = 6'd50; r.bin = 8'd200;
        send(r);
        r = blank(); r.cmd = 2'd3; r.bin = 8'hff; r.azimuth = 14'h1fff;
        r.elevation = 16'hffff; r.distance = 16'hffff; r.left_value = -1; r.right_value = -1;
        send(r);
        r = blank(); r.cmd = CMD_DWRITE; r.bin = 8'd128; r.left_value = 32'sh80000000;
        send(r);

        // directed queries: edges, wrap, fade extremes
        r = blank(); r.azimuth = -5760; r.elevation = -5760; r.distance = 0; send(r);
        r = blank(); r.azimuth = 5760; r.elevation = 17280; send(r);
        r = blank(); r.azimuth = -5120; r.elevation = -2880; send(r);
        r = blank(); r.azimuth = 5120; r.elevation = 14760; r.distance = 255; send(r);
        r = blank(); r.azimuth = 4000; r.elevation = 15000; r.distance = 128; send(r);
        r = blank(); r.azimuth = -4160; r.elevation = -3000; send(r);
        r = blank(); r.azimuth = 14'sh1fff; r.elevation = 16'sh7fff; send(r);
        r = blank(); r.azimuth = 14'sh2000; r.elevation = 16'sh8000; send(r);
        r = blank(); r.azimuth = 3000; r.elevation = 181; r.distance = 256; send(r);
        drain();

        // random phases over register settings, including nearest mode
        for (int ph = 0; ph < 6; ph++) begin
            apb_write(3'(4 * 0), 32'(ph % 2 == 0 ? 0 : 1));
            apb_write(3'(4 * 1), mds[ph]);
            if (ph == 0) begin
                r = blank(); r.azimuth = -3680; r.elevation = 180; send(r);
                r = blank(); r.azimuth = -4500; r.elevation = -5760; r.distance = 0; send(r);
            end
            if (ph == 2) hold_off = 1;
            for (int i = 0; i < 65; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = rand_query(QBINS);
                    r.cmd = $urandom_range(0, 1) ? CMD_DWRITE : CMD_TWRITE;
                    r.az_index = 5'($urandom_range(0, 24));
                    r.el_index = 6'($urandom_range(0, 49));
                    r.bin = 8'($urandom_range(0, QBINS - 1));
                    send(r);
                end else begin
                    send(rand_query(QBINS));
                end
            end
            drain();
        end

        $display("sent %0d items, %0d queries; results checked: %0d", n_items, n_queries,
                 sb.checked);
        $display("covered both modes, six fade thresholds, edge and wrap angles, stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[hrtf_grid_interpolator_top] OK");
        end else begin
            $display("failures: %0d, results missing: %0d", sb.errors, sb.pending.size());
            $display("[hrtf_grid_interpolator_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/hgi_pkg.sv
design/hgi_frac.sv
design/hgi_front.sv
design/hgi_back.sv
design/hrtf_grid_interpolator_top.sv
tb/sv/tb_hrtf_grid_interpolator_top.sv
